>>> design/crc16rc_pkg.sv
// ----------------------------------------------------------------------------
// crc16rc_pkg
// Shared types and constants for the CRC-16 read-response frame checker.
// ----------------------------------------------------------------------------
package crc16rc_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned CRC_W      = 16;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 3;

  localparam logic [CRC_W-1:0]      CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0]      CRC_POLY = 16'hA001;
  localparam logic [BYTE_W-1:0]     FUNC_CODE_RESET = 8'h03;
  localparam logic [CFG_ADDR_W-1:0] REG_FUNC_CODE_ADDR = 3'd0;

  // One received byte with its sideband.
  typedef struct packed {
    logic [LEN_W-1:0]  expected_length;
    logic              frame_start;
    logic [BYTE_W-1:0] rx_byte;
  } rx_item_t;

  // Result of one received byte.
  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              payload_valid;
    logic              frame_done;
    logic              header_ok;
    logic              crc_ok;
  } rslt_t;

endpackage

>>> design/crc16rc_crc_byte.sv
// ----------------------------------------------------------------------------
// crc16rc_crc_byte
// One-byte update of the reflected CRC-16, eight bit steps unrolled.
// ----------------------------------------------------------------------------
module crc16rc_crc_byte
  import crc16rc_pkg::*;
(
  input  logic [CRC_W-1:0]  crc_in,
  input  logic [BYTE_W-1:0] data_in,
  output logic [CRC_W-1:0]  crc_out
);

  always_comb begin
    logic [CRC_W-1:0] c;
    c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data_in};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

>>> design/crc16rc_frame.sv
// ----------------------------------------------------------------------------
// crc16rc_frame
// Frame tracking state and the per-byte result logic.
// ----------------------------------------------------------------------------
module crc16rc_frame
  import crc16rc_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 12
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  rx_item_t          item,
  input  logic [BYTE_W-1:0] func_code,
  output rslt_t             rslt
);

  // The 4-bit length field caps the payload length below MAX_PAYLOAD if needed.
  localparam int unsigned LEN_FIELD_MAX = (1 << LEN_W) - 1;
  localparam int unsigned LEN_CAP =
    (MAX_PAYLOAD < LEN_FIELD_MAX) ? MAX_PAYLOAD : LEN_FIELD_MAX;
  localparam int unsigned POS_W = $clog2(LEN_CAP + 4);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [CRC_W-1:0] crc_r, crc_nxt;
  logic             hdr_good_r, hdr_good_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             low_match_r, low_match_nxt;
  logic             active_r, active_nxt;

  logic [LEN_W-1:0] len_sat;
  logic [POS_W-1:0] pos_cur;
  logic [POS_W-1:0] len_ext;
  logic [CRC_W-1:0] crc_cur;
  logic [CRC_W-1:0] crc_upd;
  logic             hdr_cur;
  logic             low_cur;

  assign len_sat = (item.expected_length > LEN_W'(LEN_CAP)) ?
                   LEN_W'(LEN_CAP) : item.expected_length;

  // A frame start overrides the stored frame context for this byte.
  assign pos_cur = item.frame_start ? '0 : pos_r;
  assign crc_cur = item.frame_start ? CRC_INIT : crc_r;
  assign hdr_cur = item.frame_start | hdr_good_r;
  assign low_cur = item.frame_start ? 1'b0 : low_match_r;

  crc16rc_crc_byte u_crc (
    .crc_in  (crc_cur),
    .data_in (item.rx_byte),
    .crc_out (crc_upd)
  );

  always_comb begin
    len_nxt       = item.frame_start ? len_sat : len_r;
    len_ext       = POS_W'(len_nxt);
    pos_nxt       = pos_cur;
    crc_nxt       = crc_cur;
    hdr_good_nxt  = hdr_cur;
    low_match_nxt = low_cur;
    active_nxt    = item.frame_start | active_r;
    rslt          = '0;

    if (active_nxt) begin
      if (pos_cur == POS_W'(0)) begin
        if (item.rx_byte != func_code) begin
          hdr_good_nxt = 1'b0;
        end
        crc_nxt = crc_upd;
        pos_nxt = pos_cur + POS_W'(1);
      end else if (pos_cur == POS_W'(1)) begin
        if (item.rx_byte != BYTE_W'(len_nxt)) begin
          hdr_good_nxt = 1'b0;
        end
        crc_nxt = crc_upd;
        pos_nxt = pos_cur + POS_W'(1);
      end else if (pos_cur < len_ext + POS_W'(2)) begin
        rslt.payload_byte  = item.rx_byte;
        rslt.payload_valid = 1'b1;
        crc_nxt            = crc_upd;
        pos_nxt            = pos_cur + POS_W'(1);
      end else if (pos_cur == len_ext + POS_W'(2)) begin
        low_match_nxt = (item.rx_byte == crc_cur[BYTE_W-1:0]);
        pos_nxt       = pos_cur + POS_W'(1);
      end else begin
        rslt.frame_done = 1'b1;
        rslt.header_ok  = hdr_cur;
        rslt.crc_ok     = low_cur && (item.rx_byte == crc_cur[CRC_W-1:BYTE_W]);
        active_nxt      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      crc_r       <= CRC_INIT;
      hdr_good_r  <= 1'b0;
      len_r       <= '0;
      low_match_r <= 1'b0;
      active_r    <= 1'b0;
    end else if (step) begin
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      hdr_good_r  <= hdr_good_nxt;
      len_r       <= len_nxt;
      low_match_r <= low_match_nxt;
      active_r    <= active_nxt;
    end
  end

endmodule

>>> design/crc16_read_response_check_core.sv
// ----------------------------------------------------------------------------
// crc16_read_response_check_core
// Byte-wise checker for sensor read-response frames with a CRC-16 trailer.
// ----------------------------------------------------------------------------
//
// Channel | Direction | Transaction content
// --------+-----------+------------------------------------------------------
// in_     | slave     | one received byte, frame start flag, payload length
// out_    | master    | payload byte, payload flag, frame end with status
// cfg_    | APB slave | expected function code register at address 0
//
// Every accepted byte yields exactly one output transaction once the output
// side is ready: the byte first waits in the input register, then the
// frame logic and CRC update settle into the output register.
// The sustained rate is one byte per cycle while out_tready stays high; the
// eight-step CRC-16 byte update between the input and output registers
// sets the critical path. Reset (rst_n low, synchronous) empties both
// registers, clears the frame state, loads the CRC with 0xFFFF and sets the
// function code to 3. When out_tready is low the output register holds, the
// input register keeps its byte, and in_tready drops once both are full.
// ----------------------------------------------------------------------------
module crc16_read_response_check_core
  import crc16rc_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 12
)
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // [7:0] rx_byte, [11:8] expected_length
  input  logic                  in_tuser,   // [0] frame_start

  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata,  // [7:0] payload_byte, [8] header_ok,
                                            // [9] crc_ok
  output logic                  out_tuser,  // [0] payload_valid
  output logic                  out_tlast,  // frame_done

  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic              s1_valid_r, s1_valid_nxt;
  rx_item_t          s1_item_r, s1_item_nxt;
  logic              out_valid_r, out_valid_nxt;
  rslt_t             out_rslt_r, out_rslt_nxt;
  logic [BYTE_W-1:0] func_code_r, func_code_nxt;

  logic              s1_adv;
  logic              in_acc;
  logic              cfg_wr;
  logic              cfg_hit;
  rslt_t             rslt;

  // Configuration port. Only the upper address bit selects a register; the
  // byte offset within the word is ignored.
  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[CFG_ADDR_W-1:2] == REG_FUNC_CODE_ADDR[CFG_ADDR_W-1:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit;
  assign cfg_prdata = cfg_hit ? CFG_DATA_W'(func_code_r) : '0;

  assign func_code_nxt = cfg_wr ? cfg_pwdata[BYTE_W-1:0] : func_code_r;

  // The input byte moves on whenever the output register is free or drains
  // this cycle; the frame state advances in the same cycle.
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_item_nxt  = s1_item_r;
    if (in_acc) begin
      s1_valid_nxt                = 1'b1;
      s1_item_nxt.rx_byte         = in_tdata[7:0];
      s1_item_nxt.expected_length = in_tdata[11:8];
      s1_item_nxt.frame_start     = in_tuser;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  crc16rc_frame #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_adv),
    .item      (s1_item_r),
    .func_code (func_code_r),
    .rslt      (rslt)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_rslt_nxt  = out_rslt_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
      out_rslt_nxt  = rslt;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      func_code_r <= FUNC_CODE_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      func_code_r <= func_code_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r  <= s1_item_nxt;
    out_rslt_r <= out_rslt_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_rslt_r.crc_ok, out_rslt_r.header_ok,
                       out_rslt_r.payload_byte};
  assign out_tuser  = out_rslt_r.payload_valid;
  assign out_tlast  = out_rslt_r.frame_done;

  // A payload byte is never the frame's closing byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_rslt_r.payload_valid && out_rslt_r.frame_done))
    else $error("payload byte flagged as frame end");

  // Status bits are only reported on the closing byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_rslt_r.frame_done |->
      !out_rslt_r.header_ok && !out_rslt_r.crc_ok)
    else $error("status reported outside frame end");

  // Non-payload results carry a zero data byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_rslt_r.payload_valid |-> out_rslt_r.payload_byte == '0)
    else $error("data byte set on a non-payload result");

  // A byte in the input register is kept while the output side stalls.
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_tready |=> s1_valid_r && $stable(s1_item_r))
    else $error("input register lost a byte during a stall");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the CRC-16 read-response frame checker.
// Bytes are streamed into the core with random gaps and the results are
// accepted with random back-pressure. Each accepted byte is run through a
// bench-side model of the frame checker. Every output transaction is compared
// field by field against the oldest predicted verdict. The function code
// register is rewritten between phases while the core is idle.
// ----------------------------------------------------------------------------
module tb;
  import crc16rc_pkg::*;

  localparam int unsigned MAX_PAYLOAD = 12;
  // Counted bytes per random phase. Five phases give roughly 1650 bytes.
  localparam int unsigned PHASE_BYTES = 330;
  // The long receiver hold-off that forces the core to stall its input.
  localparam int unsigned LONG_HOLD = 120;
  // Bytes wait only in the core's input and output registers, so a short tail
  // catches stray output transactions after the last expected one.
  localparam int unsigned TAIL_CYCLES = 10;
  localparam int unsigned CYCLE_LIMIT = 500000;
  // An address past the single register. Writes here must have no effect.
  localparam logic [CFG_ADDR_W-1:0] UNMAPPED_ADDR = 3'd4;
  // Passed as the cut length when a frame is sent whole.
  localparam int unsigned WHOLE_FRAME = 99;

  // One byte waiting for the driver, with the idle cycles placed before it.
  typedef struct {
    rx_item_t    item;
    int unsigned gap;
  } rx_slot_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata = '0;   // [7:0] rx_byte, [11:8] expected_length
  logic                  in_tuser = 1'b0; // [0] frame_start

  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [15:0]           out_tdata;       // [7:0] payload_byte, [8] header_ok,
                                          // [9] crc_ok
  logic                  out_tuser;       // [0] payload_valid
  logic                  out_tlast;       // frame_done

  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // Bench copy of the frame checker state, in its reset condition.
  logic [BYTE_W-1:0]     func_code_model = FUNC_CODE_RESET;
  logic [LEN_W-1:0]      pos_model = '0;
  logic [LEN_W-1:0]      len_model = '0;
  logic [CRC_W-1:0]      crc_model = CRC_INIT;
  logic                  hdr_good_model = 1'b0;
  logic                  crc_lo_model = 1'b0;
  logic                  active_model = 1'b0;

  rx_slot_t              rx_bytes_q[$];   // bytes not yet offered to the core
  rslt_t                 verdict_q[$];    // predicted verdicts, oldest first

  int unsigned           queued_cnt = 0;
  int unsigned           accepted_cnt = 0;
  int unsigned           counted_bytes = 0;
  int unsigned           err_cnt = 0;
  int unsigned           hold_req_cnt = 0;
  int unsigned           cycle_cnt = 0;

  // Driver-owned state.
  rx_slot_t              cur_slot;
  rx_item_t              shown_item;
  logic                  have_slot = 1'b0;
  int unsigned           gap_left = 0;

  // Receiver-owned state.
  int unsigned           stall_left = 0;
  int unsigned           hold_ack_cnt = 0;
  logic                  quiet = 1'b0;

  crc16_read_response_check_core #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Reflected CRC-16 update for one byte, shifting out the LSB first.
  function automatic logic [CRC_W-1:0] crc16_fold(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Advances the bench model by one accepted byte and returns the verdict
  // that the core must produce for it.
  function automatic rslt_t check_byte(input rx_item_t it);
    rslt_t       r;
    int unsigned pos;
    int unsigned len;
    r = '0;
    // A frame start always abandons whatever frame was in progress.
    if (it.frame_start) begin
      len_model      = (it.expected_length > MAX_PAYLOAD) ? LEN_W'(MAX_PAYLOAD)
                                                          : it.expected_length;
      pos_model      = '0;
      crc_model      = CRC_INIT;
      hdr_good_model = 1'b1;
      crc_lo_model   = 1'b0;
      active_model   = 1'b1;
    end
    // With no frame active, the byte is dropped and gives an all-zero result.
    if (!active_model) begin
      return r;
    end
    pos = pos_model;
    len = len_model;
    if (pos == 0) begin
      if (it.rx_byte != func_code_model) begin
        hdr_good_model = 1'b0;
      end
      crc_model = crc16_fold(crc_model, it.rx_byte);
    end else if (pos == 1) begin
      // The length byte is compared with the saturated length.
      if (it.rx_byte != {4'd0, len_model}) begin
        hdr_good_model = 1'b0;
      end
      crc_model = crc16_fold(crc_model, it.rx_byte);
    end else if (pos < len + 2) begin
      r.payload_byte  = it.rx_byte;
      r.payload_valid = 1'b1;
      crc_model       = crc16_fold(crc_model, it.rx_byte);
    end else if (pos == len + 2) begin
      crc_lo_model = (it.rx_byte == crc_model[7:0]);
    end else begin
      r.frame_done = 1'b1;
      r.header_ok  = hdr_good_model;
      r.crc_ok     = crc_lo_model && (it.rx_byte == crc_model[15:8]);
      active_model = 1'b0;
      return r;
    end
    pos_model = pos_model + 1'b1;
    return r;
  endfunction

  // The driver presents the queued bytes one transaction at a time. A byte
  // waits out its own gap once the previous transaction has been accepted.
  // The prediction is made at the edge where the core takes the byte.
  always @(posedge clk) begin : byte_driver
    logic nxt_valid;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      have_slot = 1'b0;
      gap_left  = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        verdict_q.push_back(check_byte(shown_item));
        accepted_cnt++;
      end
      if (!in_tvalid || in_tready) begin
        nxt_valid = 1'b0;
        if (!have_slot && rx_bytes_q.size() > 0) begin
          cur_slot  = rx_bytes_q.pop_front();
          have_slot = 1'b1;
          gap_left  = cur_slot.gap;
        end
        if (have_slot) begin
          if (gap_left > 0) begin
            gap_left--;
          end else begin
            nxt_valid  = 1'b1;
            shown_item = cur_slot.item;
            have_slot  = 1'b0;
            in_tdata   <= {4'd0, cur_slot.item.expected_length, cur_slot.item.rx_byte};
            in_tuser   <= cur_slot.item.frame_start;
          end
        end
        in_tvalid <= nxt_valid;
      end
    end
  end

  // The receiver draws a stall after every accepted result. It drifts in and
  // out of a quiet mode with no stalls at all. A hold request from the
  // stimulus makes it refuse results for a long stretch, counted here.
  always @(posedge clk) begin : result_ready
    if (!rst_n) begin
      out_tready   <= 1'b0;
      stall_left   = 0;
      hold_ack_cnt = 0;
      quiet        = 1'b0;
    end else begin
      if (hold_ack_cnt != hold_req_cnt) begin
        hold_ack_cnt = hold_req_cnt;
        stall_left   = LONG_HOLD;
      end else if (out_tvalid && out_tready) begin
        if ($urandom_range(0, 39) == 0) begin
          quiet = !quiet;
        end
        stall_left = quiet ? 0 : $urandom_range(0, 19);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_tready <= (stall_left == 0);
    end
  end

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  // Every accepted output transaction is matched against the oldest verdict.
  always @(posedge clk) begin : result_monitor
    rslt_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: output transaction with none predicted, expected none actual %h/%b/%b",
                 $time, out_tdata, out_tuser, out_tlast);
        err_cnt++;
      end else begin
        want = verdict_q.pop_front();
        check_field("payload_byte", want.payload_byte, out_tdata[7:0]);
        check_field("payload_valid", {7'd0, want.payload_valid}, {7'd0, out_tuser});
        check_field("frame_done", {7'd0, want.frame_done}, {7'd0, out_tlast});
        check_field("header_ok", {7'd0, want.header_ok}, {7'd0, out_tdata[8]});
        check_field("crc_ok", {7'd0, want.crc_ok}, {7'd0, out_tdata[9]});
        check_field("tdata padding", 8'h00, {2'b00, out_tdata[15:10]});
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("crc16_read_response_check_core: mismatch");
      $finish;
    end
  end

  function automatic int unsigned draw_gap(input bit no_gaps);
    return no_gaps ? 0 : $urandom_range(0, 19);
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic start,
                           input logic [3:0] len, input int unsigned gap);
    rx_slot_t s;
    s.item.rx_byte         = b;
    s.item.frame_start     = start;
    s.item.expected_length = len;
    s.gap                  = gap;
    rx_bytes_q.push_back(s);
    queued_cnt++;
  endtask

  // Queues one response frame: function code, length byte, payload, then the
  // CRC trailer. crc_flip corrupts the low (bit 0) or high (bit 1) CRC byte.
  // Only the first cut bytes are sent, so a short cut leaves a frame unfinished.
  task automatic send_frame(input logic [7:0] fc_byte, input logic [3:0] len_field,
                            input logic [7:0] len_byte, input logic [1:0] crc_flip,
                            input int unsigned cut, input bit no_gaps);
    logic [7:0]       bytes[$];
    logic [CRC_W-1:0] crc;
    int unsigned      npay;
    bit               tight;
    npay = (len_field > MAX_PAYLOAD) ? MAX_PAYLOAD : len_field;
    crc  = CRC_INIT;
    bytes.push_back(fc_byte);
    bytes.push_back(len_byte);
    repeat (npay) bytes.push_back(8'($urandom));
    foreach (bytes[i]) crc = crc16_fold(crc, bytes[i]);
    bytes.push_back(crc[7:0] ^ (crc_flip[0] ? 8'($urandom_range(1, 255)) : 8'h00));
    bytes.push_back(crc[15:8] ^ (crc_flip[1] ? 8'($urandom_range(1, 255)) : 8'h00));
    // About one frame in four goes out back to back.
    tight = no_gaps || ($urandom_range(0, 3) == 0);
    for (int i = 0; i < bytes.size() && i < cut; i++) begin
      // The length field is don't-care after the first byte, so it is random.
      push_byte(bytes[i], i == 0, (i == 0) ? len_field : 4'($urandom),
                tight ? 0 : draw_gap(1'b0));
      counted_bytes++;
    end
  endtask

  // Mostly whole frames with random content, some with a bad header or CRC,
  // each of which reaches its trailer. The rest are unfinished frames, stray idle
  // bytes and lone frame starts.
  task automatic random_phase(input int unsigned target, input bit no_gaps);
    int unsigned start_cnt;
    int unsigned pick;
    int unsigned len_f;
    int unsigned total;
    logic [7:0]  fc_b;
    logic [7:0]  len_b;
    logic [1:0]  flip;
    start_cnt = counted_bytes;
    while (counted_bytes - start_cnt < target) begin
      pick  = $urandom_range(0, 99);
      len_f = ($urandom_range(0, 6) == 0) ? $urandom_range(13, 15) : $urandom_range(0, 12);
      fc_b  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : func_code_model;
      len_b = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                          : 8'((len_f > MAX_PAYLOAD) ? MAX_PAYLOAD : len_f);
      flip  = ($urandom_range(0, 6) == 0) ? 2'($urandom_range(1, 3)) : 2'b00;
      total = ((len_f > MAX_PAYLOAD) ? MAX_PAYLOAD : len_f) + 4;
      if (pick < 72) begin
        send_frame(fc_b, 4'(len_f), len_b, flip, WHOLE_FRAME, no_gaps);
      end else if (pick < 84) begin
        send_frame(fc_b, 4'(len_f), len_b, flip, $urandom_range(1, total - 1), no_gaps);
      end else if (pick < 93) begin
        // Stray bytes without a frame start. They are dropped unless an
        // unfinished frame is still open.
        repeat ($urandom_range(1, 4)) begin
          push_byte(8'($urandom), 1'b0, 4'($urandom), draw_gap(no_gaps));
        end
      end else begin
        push_byte(8'($urandom), 1'b1, 4'($urandom), draw_gap(no_gaps));
        counted_bytes++;
      end
    end
  endtask

  // Blocks until every queued byte has been taken and every verdict checked.
  task automatic drain();
    do @(negedge clk); while (accepted_cnt != queued_cnt || verdict_q.size() != 0);
  endtask

  // APB write: a setup phase, then an access phase that completes on pready.
  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    // Only the function code register exists. The model tracks writes to address 0 only.
    if (addr == REG_FUNC_CODE_ADDR) begin
      func_code_model = data[BYTE_W-1:0];
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // APB read of the function code register, checked against the model.
  task automatic check_func_code_readback();
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= REG_FUNC_CODE_ADDR;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== {{(CFG_DATA_W - BYTE_W){1'b0}}, func_code_model}) begin
      $display("%0t: function code readback expected %0h actual %0h", $time,
               func_code_model, cfg_prdata);
      err_cnt++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // The register must come out of reset holding the default function code.
    check_func_code_readback();

    // Directed frames, all checked against the reset function code.
    // An idle byte before any frame has started is dropped.
    push_byte(8'hFF, 1'b0, 4'hF, draw_gap(1'b0));
    // A clean one-byte payload frame.
    send_frame(FUNC_CODE_RESET, 4'd1, 8'd1, 2'b00, WHOLE_FRAME, 1'b0);
    // Zero length frame: header and trailer only, with a wrong function code.
    send_frame(8'h00, 4'd0, 8'd0, 2'b00, WHOLE_FRAME, 1'b0);
    // Corrupted CRC low byte.
    send_frame(FUNC_CODE_RESET, 4'd2, 8'd2, 2'b01, WHOLE_FRAME, 1'b0);
    // A byte after frame done must be ignored.
    push_byte(8'h00, 1'b0, 4'h0, draw_gap(1'b0));
    // Oversized length saturates to the maximum payload. The frame is cut
    // after its first payload byte.
    send_frame(FUNC_CODE_RESET, 4'hF, 8'(MAX_PAYLOAD), 2'b00, 3, 1'b0);
    // That frame is then abandoned by a new start. The new frame has a wrong
    // function code and length byte and a corrupted CRC high byte.
    send_frame(8'hFF, 4'd0, 8'd7, 2'b10, WHOLE_FRAME, 1'b0);
    drain();

    // Lowest function code. Upper write data bits must be discarded.
    cfg_write(REG_FUNC_CODE_ADDR, {24'($urandom), 8'h00});
    check_func_code_readback();
    random_phase(PHASE_BYTES, 1'b0);
    drain();

    // Highest function code. The receiver holds off for a long stretch while
    // the sender streams back to back, so the core has to stall its input.
    cfg_write(REG_FUNC_CODE_ADDR, {24'($urandom), 8'hFF});
    @(negedge clk);
    hold_req_cnt++;
    random_phase(PHASE_BYTES, 1'b1);
    drain();

    // A write past the register list must leave the function code alone.
    cfg_write(UNMAPPED_ADDR, '1);
    check_func_code_readback();
    random_phase(PHASE_BYTES, 1'b0);
    drain();

    cfg_write(REG_FUNC_CODE_ADDR, $urandom);
    random_phase(PHASE_BYTES, 1'b0);
    drain();

    cfg_write(REG_FUNC_CODE_ADDR, {24'($urandom), FUNC_CODE_RESET});
    random_phase(PHASE_BYTES, 1'b0);
    drain();

    // Give any extra output transaction a chance to show up.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("crc16_read_response_check_core: match");
    end else begin
      $display("crc16_read_response_check_core: mismatch");
    end
    $finish;
  end

endmodule
